[rtl/core/bpgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_pkg
// Types and constants shared by the box pair gate and score pipeline.
// ---------------------------------------------------------------------------
package bpgs_pkg;

    // Fixed point one in Q.16.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Score weights in hundredths.
    localparam logic [22:0] W_DIST      = 23'd55;
    localparam logic [22:0] W_IOU       = 23'd25;
    localparam logic [22:0] BONUS_LABEL = 23'd15 * 23'd65536;
    localparam logic [22:0] BONUS_GEOM  = 23'd10 * 23'd65536;
    localparam logic [22:0] BONUS_APP   = 23'd5 * 23'd65536;
    localparam logic [22:0] BONUS_REP   = 23'd5 * 23'd65536;
    localparam logic [22:0] ROUND_HALF  = 23'd50;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2^23.
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    // Largest score that the weights can reach.
    localparam logic [16:0] SCORE_MAX = 17'd75366;

    typedef enum logic [1:0] {
        RSN_ACCEPT = 2'd0,
        RSN_LABEL  = 2'd1,
        RSN_FAR    = 2'd2,
        RSN_LOW    = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        CFG_MAX_DIST  = 2'd0,
        CFG_MIN_SCORE = 2'd1,
        CFG_ALLOW_MIS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic lab_mismatch;
        logic lab_bonus;
        logic geo_bonus;
        logic app_bonus;
        logic rep_bonus;
        logic too_far;
        logic uni_zero;
    } t_pair_flags;

    typedef struct packed {
        t_pair_flags flags;
        logic [16:0] cdist;
        logic [16:0] iou;
        logic        sat;
        logic        mzero;
    } t_ratio_tag;

    // Extent of one axis; an inverted interval counts as empty.
    function automatic logic [15:0] f_extent(logic signed [15:0] lo, logic signed [15:0] hi);
        return (hi > lo) ? 16'(hi - lo) : 16'd0;
    endfunction

endpackage
`default_nettype wire

[rtl/core/box_pair_gate_and_score_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// box_pair_gate_and_score_unit
// Gates and scores one tracked / observed 3D box pair per item.
// ---------------------------------------------------------------------------
// Input items arrive on the i_s_* stream, one box pair each; results leave on
// the o_m_* stream, one per input item, in order. The user must write registers
// on the i_cfg_* port only while no item is in flight; the block does not check.
// The pipeline is 42 stages deep: four geometry stages, an 18 stage square
// root running beside an 18 stage IoU divider, a 17 stage divider for the
// distance term and three score stages. One item is accepted every cycle
// while the receiver keeps up; each divider and root stage resolves one bit.
// The whole pipeline advances together: when a result waits with i_m_tready
// low, o_s_tready drops and every stage holds, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module box_pair_gate_and_score_unit import bpgs_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // prev_min_corner, prev_max_corner, obs_min_corner, obs_max_corner,
    // prev_label, obs_label, prev_geometry_sig, obs_geometry_sig,
    // prev_appearance_sig, obs_appearance_sig, prev_representation,
    // obs_representation
    input  wire logic [487:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // reject_reason, score, center_distance, overlap_ratio, zero padding
    output logic [55:0]       o_m_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [16:0]  i_cfg_wdata
);

    logic        w_mzero;
    logic [15:0] r_max_dist_q;
    logic [16:0] r_min_score;
    logic        r_allow;
    logic        w_en;

    logic        g_valid;
    logic [35:0] g_sumsq;
    logic [63:0] g_num;
    logic [48:0] g_union;
    t_pair_flags g_flags;

    logic        q_valid;
    logic [17:0] q_root;
    logic        d_valid;
    logic [17:0] d_quo;
    logic [$bits(t_pair_flags)-1:0] d_tag;
    t_pair_flags d_flags;

    t_ratio_tag  w_rtag;
    logic        r_valid_o;
    logic [16:0] r_ratio;
    logic [$bits(t_ratio_tag)-1:0] r_tag_vec;

    logic        o_vld;
    logic [1:0]  o_reason;
    logic [16:0] o_score, o_dist, o_iou;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist_q <= 16'd640;
            r_min_score  <= 17'd0;
            r_allow      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_DIST:  r_max_dist_q <= i_cfg_wdata[15:0];
                CFG_MIN_SCORE: r_min_score  <= i_cfg_wdata;
                CFG_ALLOW_MIS: r_allow      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_mzero = (r_max_dist_q == 16'd0);

    assign w_en       = !o_vld || i_m_tready;
    assign o_s_tready = w_en;

    bpgs_geom u_geom (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_en                  (w_en),
        .i_valid               (i_s_tvalid),
        .i_prev_min_corner     (i_s_tdata[47:0]),
        .i_prev_max_corner     (i_s_tdata[95:48]),
        .i_obs_min_corner      (i_s_tdata[143:96]),
        .i_obs_max_corner      (i_s_tdata[191:144]),
        .i_prev_label          (i_s_tdata[207:192]),
        .i_obs_label           (i_s_tdata[223:208]),
        .i_prev_geometry_sig   (i_s_tdata[287:224]),
        .i_obs_geometry_sig    (i_s_tdata[351:288]),
        .i_prev_appearance_sig (i_s_tdata[415:352]),
        .i_obs_appearance_sig  (i_s_tdata[479:416]),
        .i_prev_representation (i_s_tdata[483:480]),
        .i_obs_representation  (i_s_tdata[487:484]),
        .i_max_dist            (r_max_dist_q),
        .i_allow_mismatch      (r_allow),
        .o_valid               (g_valid),
        .o_sumsq               (g_sumsq),
        .o_iou_num             (g_num),
        .o_union               (g_union),
        .o_flags               (g_flags)
    );

    bpgs_sqrt #(.VW(36)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (g_valid),
        .i_value (g_sumsq),
        .o_valid (q_valid),
        .o_root  (q_root)
    );

    // An 18 bit quotient keeps this divider level with the square root.
    bpgs_div #(.NW(64), .DW(49), .QW(18), .TW($bits(t_pair_flags))) u_iou_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (g_valid),
        .i_num   (g_num),
        .i_den   (g_union),
        .i_tag   (g_flags),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_tag   (d_tag)
    );

    assign d_flags = t_pair_flags'(d_tag);

    always_comb begin
        w_rtag.flags = d_flags;
        w_rtag.cdist = q_root[17:1];
        w_rtag.iou   = d_flags.uni_zero ? 17'd0 : d_quo[16:0];
        // Beyond the limit the ratio clamps to one and the quotient is ignored.
        w_rtag.sat   = q_root[17:1] > {1'b0, r_max_dist_q};
        w_rtag.mzero = w_mzero;
    end

    bpgs_div #(.NW(33), .DW(16), .QW(17), .TW($bits(t_ratio_tag))) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (q_valid && d_valid),
        .i_num   ({q_root[17:1], 16'd0}),
        .i_den   (r_max_dist_q),
        .i_tag   (w_rtag),
        .o_valid (r_valid_o),
        .o_quo   (r_ratio),
        .o_tag   (r_tag_vec)
    );

    bpgs_score u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (r_valid_o),
        .i_ratio     (r_ratio),
        .i_tag       (t_ratio_tag'(r_tag_vec)),
        .i_min_score (r_min_score),
        .o_valid     (o_vld),
        .o_reason    (o_reason),
        .o_score     (o_score),
        .o_dist      (o_dist),
        .o_iou       (o_iou)
    );

    assign o_m_tvalid = o_vld;
    assign o_m_tdata  = {3'b000, o_iou, o_dist, o_score, o_reason};

endmodule
`default_nettype wire

[rtl/core/bpgs_geom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_geom
// Four stage front end: center offsets, extents, squares, volumes, union.
// ---------------------------------------------------------------------------
module bpgs_geom import bpgs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [47:0] i_prev_min_corner,
    input  wire logic [47:0] i_prev_max_corner,
    input  wire logic [47:0] i_obs_min_corner,
    input  wire logic [47:0] i_obs_max_corner,
    input  wire logic [15:0] i_prev_label,
    input  wire logic [15:0] i_obs_label,
    input  wire logic [63:0] i_prev_geometry_sig,
    input  wire logic [63:0] i_obs_geometry_sig,
    input  wire logic [63:0] i_prev_appearance_sig,
    input  wire logic [63:0] i_obs_appearance_sig,
    input  wire logic [3:0]  i_prev_representation,
    input  wire logic [3:0]  i_obs_representation,
    input  wire logic [15:0] i_max_dist,
    input  wire logic        i_allow_mismatch,
    output logic             o_valid,
    output logic [35:0]      o_sumsq,
    output logic [63:0]      o_iou_num,
    output logic [48:0]      o_union,
    output t_pair_flags      o_flags
);

    logic               r_v [4];
    logic signed [18:0] n_s1_ofs [3];
    logic [15:0]        n_s1_ep [3];
    logic [15:0]        n_s1_eo [3];
    logic [15:0]        n_s1_ei [3];
    t_pair_flags        n_s1_flags;
    logic signed [18:0] r_s1_ofs [3];
    logic [15:0]        r_s1_ep [3];
    logic [15:0]        r_s1_eo [3];
    logic [15:0]        r_s1_ei [3];
    t_pair_flags        r_s1_flags;
    logic [34:0]        r_s2_sq [3];
    logic [31:0]        r_s2_pxy, r_s2_oxy, r_s2_ixy;
    logic [15:0]        r_s2_pz, r_s2_oz, r_s2_iz;
    t_pair_flags        r_s2_flags;
    logic [35:0]        r_s3_sumsq;
    logic [47:0]        r_s3_vp, r_s3_vo, r_s3_vi;
    t_pair_flags        r_s3_flags;
    logic [35:0]        r_s4_sumsq;
    logic [63:0]        r_s4_num;
    logic [48:0]        r_s4_union;
    t_pair_flags        n_s4_flags;
    t_pair_flags        r_s4_flags;
    logic [31:0]        w_max_sq;
    logic [48:0]        w_union;

    always_comb begin
        logic signed [15:0] p0, p1, o0, o1, ilo, ihi;
        for (int a = 0; a < 3; a++) begin
            p0  = signed'(i_prev_min_corner[16*a +: 16]);
            p1  = signed'(i_prev_max_corner[16*a +: 16]);
            o0  = signed'(i_obs_min_corner[16*a +: 16]);
            o1  = signed'(i_obs_max_corner[16*a +: 16]);
            ilo = (p0 > o0) ? p0 : o0;
            ihi = (p1 < o1) ? p1 : o1;
            // Twice the center offset, so no half bit is lost.
            n_s1_ofs[a] = 19'(p0) + 19'(p1) - 19'(o0) - 19'(o1);
            n_s1_ep[a]  = f_extent(p0, p1);
            n_s1_eo[a]  = f_extent(o0, o1);
            n_s1_ei[a]  = f_extent(ilo, ihi);
        end
        n_s1_flags.lab_mismatch = !i_allow_mismatch && (i_prev_label != 16'd0)
                                  && (i_obs_label != 16'd0) && (i_prev_label != i_obs_label);
        n_s1_flags.lab_bonus = (i_prev_label != 16'd0) && (i_prev_label == i_obs_label);
        n_s1_flags.geo_bonus = (i_prev_geometry_sig != 64'd0)
                               && (i_prev_geometry_sig == i_obs_geometry_sig);
        n_s1_flags.app_bonus = (i_prev_appearance_sig != 64'd0)
                               && (i_prev_appearance_sig == i_obs_appearance_sig);
        n_s1_flags.rep_bonus = (i_prev_representation == i_obs_representation);
        n_s1_flags.too_far   = 1'b0;
        n_s1_flags.uni_zero  = 1'b0;
    end

    assign w_max_sq = 32'(i_max_dist) * 32'(i_max_dist);
    assign w_union  = 49'(r_s3_vp) + 49'(r_s3_vo) - 49'(r_s3_vi);

    always_comb begin
        n_s4_flags = r_s3_flags;
        // Squared offsets are four times the squared distance.
        n_s4_flags.too_far  = r_s3_sumsq > 36'({w_max_sq, 2'b00});
        n_s4_flags.uni_zero = (w_union == 49'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 4; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ofs   <= n_s1_ofs;
            r_s1_ep    <= n_s1_ep;
            r_s1_eo    <= n_s1_eo;
            r_s1_ei    <= n_s1_ei;
            r_s1_flags <= n_s1_flags;

            for (int a = 0; a < 3; a++) begin
                r_s2_sq[a] <= 35'(r_s1_ofs[a] * r_s1_ofs[a]);
            end
            r_s2_pxy   <= 32'(r_s1_ep[0]) * 32'(r_s1_ep[1]);
            r_s2_oxy   <= 32'(r_s1_eo[0]) * 32'(r_s1_eo[1]);
            r_s2_ixy   <= 32'(r_s1_ei[0]) * 32'(r_s1_ei[1]);
            r_s2_pz    <= r_s1_ep[2];
            r_s2_oz    <= r_s1_eo[2];
            r_s2_iz    <= r_s1_ei[2];
            r_s2_flags <= r_s1_flags;

            r_s3_sumsq <= 36'(r_s2_sq[0]) + 36'(r_s2_sq[1]) + 36'(r_s2_sq[2]);
            r_s3_vp    <= 48'(r_s2_pxy) * 48'(r_s2_pz);
            r_s3_vo    <= 48'(r_s2_oxy) * 48'(r_s2_oz);
            r_s3_vi    <= 48'(r_s2_ixy) * 48'(r_s2_iz);
            r_s3_flags <= r_s2_flags;

            r_s4_sumsq <= r_s3_sumsq;
            r_s4_num   <= {r_s3_vi, 16'd0};
            r_s4_union <= w_union;
            r_s4_flags <= n_s4_flags;
        end
    end

    assign o_valid   = r_v[3];
    assign o_sumsq   = r_s4_sumsq;
    assign o_iou_num = r_s4_num;
    assign o_union   = r_s4_union;
    assign o_flags   = r_s4_flags;

endmodule
`default_nettype wire

[rtl/core/bpgs_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_sqrt
// Pipelined integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module bpgs_sqrt #(
    parameter int VW = 36
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [VW-1:0]   i_value,
    output logic                 o_valid,
    output logic [VW/2-1:0]      o_root
);

    localparam int RW = VW / 2;
    localparam int EW = VW + 2;

    logic [EW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic          r_vld  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int K = RW - 1 - j;
        logic [EW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic          vld_in;
        logic [EW-1:0] inc;

        if (j == 0) begin : g_first
            assign rem_in  = EW'(i_value);
            assign root_in = '0;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign vld_in  = r_vld[j-1];
        end

        // (root + 2^K)^2 - root^2
        assign inc = (EW'(root_in) << (K + 1)) + (EW'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= inc) begin
                    r_rem[j]  <= rem_in - inc;
                    r_root[j] <= root_in | (RW'(1) << K);
                end else begin
                    r_rem[j]  <= rem_in;
                    r_root[j] <= root_in;
                end
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];

endmodule
`default_nettype wire

[rtl/core/bpgs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. The quotient must fit in QW bits.
// ---------------------------------------------------------------------------
module bpgs_div #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int QW = 17,
    parameter int TW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [TW-1:0] r_tag [QW];
    logic          r_vld [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [W-1:0]  rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [TW-1:0] tag_in;
        logic          vld_in;
        logic [W-1:0]  trial;

        if (j == 0) begin : g_first
            assign rem_in = W'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign tag_in = i_tag;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign tag_in = r_tag[j-1];
            assign vld_in = r_vld[j-1];
        end

        assign trial = W'(den_in) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[j] <= rem_in - trial;
                    r_quo[j] <= quo_in | (QW'(1) << K);
                end else begin
                    r_rem[j] <= rem_in;
                    r_quo[j] <= quo_in;
                end
                r_den[j] <= den_in;
                r_tag[j] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule
`default_nettype wire

[rtl/core/bpgs_score.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_score
// Weighted score sum, rounding division by 100 and the three gates. The
// last stage is the output register of the block.
// ---------------------------------------------------------------------------
module bpgs_score import bpgs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [16:0] i_ratio,
    input  wire t_ratio_tag  i_tag,
    input  wire logic [16:0] i_min_score,
    output logic             o_valid,
    output logic [1:0]       o_reason,
    output logic [16:0]      o_score,
    output logic [16:0]      o_dist,
    output logic [16:0]      o_iou
);

    logic        r_v [3];
    logic [16:0] w_ratio;
    logic [16:0] w_dterm;
    logic [22:0] n_num;
    logic [22:0] r_s1_num;
    t_pair_flags r_s1_flags, r_s2_flags;
    logic [16:0] r_s1_dist, r_s1_iou, r_s2_dist, r_s2_iou;
    logic [46:0] r_s2_prod;
    logic [16:0] w_score;
    t_reason     n_reason;
    t_reason     r_reason;
    logic [16:0] r_score, r_dist, r_iou;

    always_comb begin
        if (i_tag.sat) begin
            w_ratio = ONE_Q16;
        end else if (i_tag.mzero) begin
            w_ratio = 17'd0;
        end else begin
            w_ratio = i_ratio;
        end
        w_dterm = ONE_Q16 - w_ratio;
        n_num = W_DIST * 23'(w_dterm) + W_IOU * 23'(i_tag.iou);
        if (i_tag.flags.lab_bonus) n_num = n_num + BONUS_LABEL;
        if (i_tag.flags.geo_bonus) n_num = n_num + BONUS_GEOM;
        if (i_tag.flags.app_bonus) n_num = n_num + BONUS_APP;
        if (i_tag.flags.rep_bonus) n_num = n_num + BONUS_REP;
    end

    assign w_score = 17'(r_s2_prod >> RECIP_SHIFT);

    always_comb begin
        if (r_s2_flags.lab_mismatch) begin
            n_reason = RSN_LABEL;
        end else if (r_s2_flags.too_far) begin
            n_reason = RSN_FAR;
        end else if (w_score < i_min_score) begin
            n_reason = RSN_LOW;
        end else begin
            n_reason = RSN_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_num   <= n_num;
            r_s1_flags <= i_tag.flags;
            r_s1_dist  <= i_tag.cdist;
            r_s1_iou   <= i_tag.iou;

            r_s2_prod  <= 47'(r_s1_num + ROUND_HALF) * 47'(RECIP_100);
            r_s2_flags <= r_s1_flags;
            r_s2_dist  <= r_s1_dist;
            r_s2_iou   <= r_s1_iou;

            r_reason   <= n_reason;
            r_score    <= w_score;
            r_dist     <= r_s2_dist;
            r_iou      <= r_s2_iou;
        end
    end

    assign o_valid  = r_v[2];
    assign o_reason = r_reason;
    assign o_score  = r_score;
    assign o_dist   = r_dist;
    assign o_iou    = r_iou;

endmodule
`default_nettype wire

[rtl/core/bpgs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bpgs_checker
// Port level checks on the box pair gate and score unit.
// ---------------------------------------------------------------------------
module bpgs_checker import bpgs_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [55:0] o_m_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // The input side stalls only while a result waits.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled without a waiting result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:2] <= SCORE_MAX) && (o_m_tdata[52:36] <= ONE_Q16)
                       && (o_m_tdata[55:53] == 3'b000))
        else $error("result field out of range");

endmodule

bind box_pair_gate_and_score_unit bpgs_checker u_bpgs_checker (.*);
`default_nettype wire

[bench/tb_box_pair_gate_and_score_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_box_pair_gate_and_score_unit
// Self-checking bench for the box pair gate and score pipeline.
// ---------------------------------------------------------------------------
// Box pairs are pushed into a queue by the stimulus process and streamed by a
// clocked driver with random gaps. A behavioral scorer computes the expected
// reason, score, distance and IoU for every accepted pair; a clocked monitor
// compares each result under random back-pressure. Several register settings
// are visited, each written while the pipeline is empty.
// ---------------------------------------------------------------------------
module tb_box_pair_gate_and_score_unit;
    import bpgs_pkg::*;

    typedef struct packed {
        logic [3:0]  obs_rep;
        logic [3:0]  prev_rep;
        logic [63:0] obs_app;
        logic [63:0] prev_app;
        logic [63:0] obs_geo;
        logic [63:0] prev_geo;
        logic [15:0] obs_lab;
        logic [15:0] prev_lab;
        logic [47:0] obs_max;
        logic [47:0] obs_min;
        logic [47:0] prev_max;
        logic [47:0] prev_min;
    } t_pair;

    typedef struct packed {
        logic [16:0] iou;
        logic [16:0] cdist;
        logic [16:0] score;
        logic [1:0]  reason;
    } t_verdict;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [487:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [55:0]  o_m_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [16:0]  i_cfg_wdata;

    box_pair_gate_and_score_unit dut (.*);

    localparam int LATENCY = 42;

    logic [15:0] max_dist;
    logic [16:0] min_score;
    logic        allow_mis;

    t_pair    pair_q[$];
    t_verdict verdict_q[$];
    int       fails, n_results, n_far, n_low, n_label;
    bit       hold_sink, stim_done;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span(longint lo, longint hi);
        return hi > lo ? longint'(hi - lo) : 0;
    endfunction

    function automatic t_verdict score_pair(t_pair p);
        t_verdict v;
        longint p0, p1, o0, o1, s;
        longint unsigned sumsq, vp, vo, vi, uni, iou, cd, ratio, num, sc;
        sumsq = 0; vp = 1; vo = 1; vi = 1;
        for (int a = 0; a < 3; a++) begin
            p0 = longint'($signed(p.prev_min[16*a +: 16]));
            p1 = longint'($signed(p.prev_max[16*a +: 16]));
            o0 = longint'($signed(p.obs_min[16*a +: 16]));
            o1 = longint'($signed(p.obs_max[16*a +: 16]));
            s = (p0 + p1) - (o0 + o1);
            sumsq += s * s;
            vp *= span(p0, p1);
            vo *= span(o0, o1);
            vi *= span(p0 > o0 ? p0 : o0, p1 < o1 ? p1 : o1);
        end
        cd = root_floor(sumsq) >> 1;
        if (cd > 131071) cd = 131071;
        uni = vp + vo - vi;
        iou = 0;
        if (uni != 0) begin
            // vi * 65536 stays below 2^64; the division runs in wider arithmetic anyway.
            iou = 64'((128'(vi) << 16) / 128'(uni));
            if (iou > 65536) iou = 65536;
        end
        if (max_dist == 0) ratio = (cd == 0) ? 0 : 65536;
        else begin
            ratio = (cd << 16) / max_dist;
            if (ratio > 65536) ratio = 65536;
        end
        num = 55 * (65536 - ratio) + 25 * iou;
        if (p.prev_lab != 0 && p.prev_lab == p.obs_lab) num += 15 * 65536;
        if (p.prev_geo != 0 && p.prev_geo == p.obs_geo) num += 10 * 65536;
        if (p.prev_app != 0 && p.prev_app == p.obs_app) num += 5 * 65536;
        if (p.prev_rep == p.obs_rep) num += 5 * 65536;
        sc = (num + 50) / 100;
        if (!allow_mis && p.prev_lab != 0 && p.obs_lab != 0 && p.prev_lab != p.obs_lab)
            v.reason = RSN_LABEL;
        else if (sumsq > 4 * longint'(max_dist) * longint'(max_dist))
            v.reason = RSN_FAR;
        else if (sc < min_score)
            v.reason = RSN_LOW;
        else
            v.reason = RSN_ACCEPT;
        v.score = sc[16:0];
        v.cdist = cd[16:0];
        v.iou   = iou[16:0];
        return v;
    endfunction

    // Driver: each item waits a random gap, then is held until taken.
    int src_gap;
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_gap    <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            verdict_q = {verdict_q, score_pair(t_pair'(i_s_tdata))};
            void'(pair_q.pop_front());
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            // With no gap the next item follows in the very next cycle.
            if (gap == 0 && pair_q.size() > 0) begin
                i_s_tdata  <= 488'(pair_q[0]);
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
            src_gap    <= gap;
        end else if (!i_s_tvalid) begin
            if (src_gap > 0) src_gap <= src_gap - 1;
            else if (pair_q.size() > 0) begin
                i_s_tdata  <= 488'(pair_q[0]);
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // Monitor: random stalls per result, with an occasional long hold-off.
    int snk_gap;
    always @(posedge i_clk) begin
        t_verdict got, want;
        int gap;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            snk_gap    <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_verdict'(o_m_tdata[52:0]);
                n_results++;
                if (verdict_q.size() == 0) begin
                    $error("result with nothing expected: %h", o_m_tdata);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    case (want.reason)
                        RSN_FAR:   n_far++;
                        RSN_LOW:   n_low++;
                        RSN_LABEL: n_label++;
                        default: ;
                    endcase
                    if (got.reason !== want.reason) begin
                        $error("reject_reason exp %0d got %0d", want.reason, got.reason);
                        fails++;
                    end
                    if (got.score !== want.score) begin
                        $error("score exp %0d got %0d", want.score, got.score);
                        fails++;
                    end
                    if (got.cdist !== want.cdist) begin
                        $error("center_distance exp %0d got %0d", want.cdist, got.cdist);
                        fails++;
                    end
                    if (got.iou !== want.iou) begin
                        $error("overlap_ratio exp %0d got %0d", want.iou, got.iou);
                        fails++;
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                i_m_tready <= (gap == 0) && !hold_sink;
                snk_gap    <= gap;
            end else if (!i_m_tready) begin
                if (snk_gap > 0) snk_gap <= snk_gap - 1;
                else if (!hold_sink) i_m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [16:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_MAX_DIST:  max_dist  = val[15:0];
            CFG_MIN_SCORE: min_score = val;
            default:       allow_mis = val[0];
        endcase
    endtask

    task automatic drain();
        while (pair_q.size() > 0 || verdict_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [47:0] corner(int lo, int hi);
        logic [47:0] c;
        for (int a = 0; a < 3; a++) c[16*a +: 16] = 16'($urandom_range(lo, hi) - 32768);
        return c;
    endfunction

    // Mostly overlapping boxes near each other with related tags; the rest raw noise.
    function automatic t_pair rand_pair();
        t_pair p;
        int base, sz;
        p = t_pair'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) != 0) begin
            base = $urandom_range(30000, 35000);
            sz   = $urandom_range(1, 600);
            p.prev_min = corner(base, base + 40);
            p.prev_max = corner(base + sz, base + sz + 40);
            p.obs_min  = corner(base - 60, base + 100);
            p.obs_max  = corner(base + sz - 60, base + sz + 100);
            if ($urandom_range(0, 7) == 0) p.obs_max = p.obs_min;
            p.prev_lab = 16'($urandom_range(0, 3));
            p.obs_lab  = $urandom_range(0, 1) ? p.prev_lab : 16'($urandom_range(0, 3));
            p.prev_geo = $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(0, 2));
            p.obs_geo  = $urandom_range(0, 1) ? p.prev_geo : p.obs_geo;
            p.prev_app = $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(0, 2));
            p.obs_app  = $urandom_range(0, 1) ? p.prev_app : p.obs_app;
            if ($urandom_range(0, 1)) p.obs_rep = p.prev_rep;
        end
        return p;
    endfunction

    initial begin
        t_pair p;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MAX_DIST;
        i_cfg_wdata = '0;
        i_s_tdata = '0;
        hold_sink = 0;
        stim_done = 0;
        fails = 0; n_results = 0; n_far = 0; n_low = 0; n_label = 0;
        max_dist = 16'd640;
        min_score = 17'd0;
        allow_mis = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs at the reset setting.
        p = '0;
        pair_q = {pair_q, p};                      // all zero: empty union
        p.prev_max = {3{16'sd64}}; p.obs_max = {3{16'sd64}};
        p.prev_lab = 16'd7; p.obs_lab = 16'd7;
        p.prev_geo = 64'd5; p.obs_geo = 64'd5;
        p.prev_app = '1; p.obs_app = '1;
        pair_q = {pair_q, p};                      // identical boxes, every bonus
        p.obs_lab = 16'd8;
        pair_q = {pair_q, p};                      // label mismatch
        p.obs_lab = 16'd0;
        pair_q = {pair_q, p};                      // one empty label
        p = '0;
        p.prev_min = {3{16'h8000}}; p.prev_max = {3{16'h7fff}};
        p.obs_min  = {3{16'h7fff}}; p.obs_max  = {3{16'h8000}};
        p.prev_rep = 4'hf; p.prev_lab = 16'hffff; p.obs_lab = 16'hffff;
        pair_q = {pair_q, p};                      // extremes, inverted observed box
        p.obs_min = {3{16'h8000}}; p.obs_max = {3{16'h7fff}};
        pair_q = {pair_q, p};                      // full range both
        p.prev_min = {3{16'h7fff}}; p.prev_max = {3{16'h7fff}};
        pair_q = {pair_q, p};                      // far apart
        p = '0;
        p.prev_max = 48'h0040_0040_0040; p.obs_min = 48'h0020_0020_0020;
        p.obs_max = 48'h0060_0060_0060; p.prev_geo = '1; p.obs_geo = 64'd1;
        pair_q = {pair_q, p};                      // partial overlap
        for (int i = 0; i < 12; i++) pair_q = {pair_q, rand_pair()};
        drain();

        // Sender pauses until all results are back, between bursts.
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin write_reg(CFG_MAX_DIST, 17'd0); write_reg(CFG_ALLOW_MIS, 17'd1); end
                1: begin write_reg(CFG_MAX_DIST, 17'd65535); write_reg(CFG_MIN_SCORE, 17'h1ffff); end
                2: begin write_reg(CFG_MAX_DIST, 17'd1); write_reg(CFG_MIN_SCORE, 17'd0); end
                default: begin
                    write_reg(CFG_MAX_DIST, 17'd640);
                    write_reg(CFG_MIN_SCORE, 17'd50000);
                    write_reg(CFG_ALLOW_MIS, 17'd0);
                end
            endcase
            for (int i = 0; i < 150; i++) pair_q = {pair_q, rand_pair()};
            drain();
        end

        // Long receiver hold-off while the sender keeps offering items.
        hold_sink = 1;
        for (int i = 0; i < 200; i++) pair_q = {pair_q, rand_pair()};
        repeat (300) @(posedge i_clk);
        hold_sink = 0;
        drain();

        for (int k = 0; k < 6; k++) begin
            write_reg(CFG_MAX_DIST, 17'($urandom_range(1, 2000)));
            write_reg(CFG_MIN_SCORE, 17'($urandom_range(0, 80000)));
            write_reg(CFG_ALLOW_MIS, 17'($urandom_range(0, 1)));
            for (int i = 0; i < 130; i++) pair_q = {pair_q, rand_pair()};
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("Checked %0d results over several register settings.", n_results);
        $display("Rejections: %0d label, %0d distance, %0d low score.",
                 n_label, n_far, n_low);
        if (fails == 0 && verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bpgs_pkg.sv
rtl/core/bpgs_geom.sv
rtl/core/bpgs_sqrt.sv
rtl/core/bpgs_div.sv
rtl/core/bpgs_score.sv
rtl/core/box_pair_gate_and_score_unit.sv
rtl/core/bpgs_checker.sv
bench/tb_box_pair_gate_and_score_unit.sv
